// ===== src/chct_pkg.sv =====
package chct_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MULT_1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MULT_2   = 64'h94d049bb133111eb;

    localparam logic [1:0] REQ_REQUEST  = 2'd0;
    localparam logic [1:0] REQ_RESPONSE = 2'd1;
    localparam logic [1:0] REQ_DATA     = 2'd2;
    localparam logic [1:0] REQ_TICK     = 2'd3;

    localparam logic [1:0] KIND_REJECT    = 2'd0;
    localparam logic [1:0] KIND_CHALLENGE = 2'd1;
    localparam logic [1:0] KIND_DATA      = 2'd2;

    localparam logic REASON_PROTOCOL = 1'b0;
    localparam logic REASON_VERSION  = 1'b1;

    localparam logic [1:0] CFG_PROTOCOL = 2'd0;
    localparam logic [1:0] CFG_VERSION  = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;
    localparam logic [1:0] CFG_SEED     = 2'd3;

    localparam logic [15:0] INTERVAL_RESET = 16'd200;

    // Request to the shared multiplier: product of a and b modulo 2^64.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    // Request to the challenge generator.
    typedef struct packed {
        logic        start;
        logic        load;
        logic [63:0] seed;
    } mix_req_t;

endpackage

// ===== src/chct_mul.sv =====
// Iterative 64 x 64 multiplier, low 64 bits of the product only.
// One 32 x 32 multiplier is used for three partial products.
module chct_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  chct_pkg::mul_req_t req,
    output logic              done,
    output logic [63:0]       product
);

    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  step_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] sel_a;
    logic [31:0] sel_b;
    logic [63:0] prod_c;

    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                sel_a = a_reg[31:0];
                sel_b = b_reg[31:0];
            end
            2'd1:
            begin
                sel_a = a_reg[31:0];
                sel_b = b_reg[63:32];
            end
            default:
            begin
                sel_a = a_reg[63:32];
                sel_b = b_reg[31:0];
            end
        endcase
        prod_c = {32'd0, sel_a} * {32'd0, sel_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg != 2'd3)
            begin
                prod_reg <= prod_c;
            end
            if (step_reg == 2'd1)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            else if (step_reg != 2'd0)
            begin
                acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== src/chct_mix.sv =====
// Challenge generator: advances the generator state and scrambles it with
// two multiplies, both run on the shared iterative multiplier.
module chct_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  chct_pkg::mix_req_t req,
    output logic              done,
    output logic [63:0]       value
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MUL1 = 2'd1;
    localparam logic [1:0] M_MUL2 = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [63:0]        rng_reg;
    logic [63:0]        rng_sum;
    logic [63:0]        value_reg;
    logic               done_reg;
    chct_pkg::mul_req_t mul_req;
    logic               mul_done;
    logic [63:0]        mul_product;

    chct_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    assign rng_sum = rng_reg + chct_pkg::GOLDEN_GAMMA;

    always_comb
    begin
        state_next    = state_reg;
        mul_req.start = 1'b0;
        mul_req.a     = rng_sum ^ (rng_sum >> 30);
        mul_req.b     = chct_pkg::MIX_MULT_1;
        unique case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    mul_req.start = 1'b1;
                    state_next    = M_MUL1;
                end
            end
            M_MUL1:
            begin
                mul_req.a = mul_product ^ (mul_product >> 27);
                mul_req.b = chct_pkg::MIX_MULT_2;
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    state_next    = M_MUL2;
                end
            end
            M_MUL2:
            begin
                if (mul_done)
                begin
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            rng_reg   <= 64'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == M_MUL2) && mul_done;
            if (req.load)
            begin
                rng_reg <= req.seed;
            end
            else if ((state_reg == M_IDLE) && req.start)
            begin
                rng_reg <= rng_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == M_MUL2) && mul_done)
        begin
            value_reg <= mul_product ^ (mul_product >> 31);
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

// ===== src/challenge_handshake_connection_table.sv =====
// Channel  | Handshake              | Carries
// ---------+------------------------+-------------------------------------------
// in       | in_valid / in_stall    | req_type, peer_address, protocol_in, ...
// out      | out_valid / out_stall  | packet_kind, dest_address, ..., last_of_run
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item at a time; in_stall stays high from the accepting edge until the item is done.
// A request first goes through the header check. It then walks the pending table, reading
// each slot and evaluating an occupied one, and then runs the challenge: two 64-bit
// multiplies of 4 steps each on one 32 x 32 multiplier.
// A rejected request goes from the check to a state that loads the result register.
// Responses, data and ticks walk their tables in the same way; a tick ends in a flush state
// that releases its last result.
// Reset clears the valid bits of both tables; entry contents need no clearing.
// An output stall holds a reject or the table walk of a tick until the result register frees.
module challenge_handshake_connection_table #(
    parameter int PENDING_SLOTS = 8,
    parameter int LINKED_SLOTS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [47:0] peer_address,
    input  logic [31:0] protocol_in,
    input  logic [7:0]  version_in,
    input  logic [63:0] key_or_response,
    input  logic [31:0] sequence_in,
    input  logic [31:0] now_ticks,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  packet_kind,
    output logic [47:0] dest_address,
    output logic        reject_reason,
    output logic [63:0] challenge_value,
    output logic [31:0] server_sequence,
    output logic [31:0] ack_number,
    output logic [31:0] elapsed_ticks,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int PIW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int LIW = (LINKED_SLOTS > 1) ? $clog2(LINKED_SLOTS) : 1;
    localparam logic [PIW-1:0] P_LAST = PIW'(PENDING_SLOTS - 1);
    localparam logic [LIW-1:0] L_LAST = LIW'(LINKED_SLOTS - 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_REJ   = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PEV   = 4'd4;
    localparam logic [3:0] S_GEN   = 4'd5;
    localparam logic [3:0] S_LRD   = 4'd6;
    localparam logic [3:0] S_LEV   = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    logic [3:0] state_reg, state_next;

    // Item currently being worked on.
    logic [1:0]  typ_reg;
    logic [47:0] addr_reg;
    logic [31:0] proto_reg;
    logic [7:0]  ver_reg;
    logic [63:0] key_reg;
    logic [31:0] seq_reg;
    logic [31:0] now_reg;

    // Configuration.
    logic [31:0] exp_proto_reg;
    logic [7:0]  exp_ver_reg;
    logic [15:0] interval_reg;

    // Table valid bits and walk indexes.
    logic [PENDING_SLOTS-1:0] p_valid_reg, p_valid_next;
    logic [LINKED_SLOTS-1:0]  l_valid_reg, l_valid_next;
    logic [PIW-1:0] p_idx_reg, p_idx_next, pf_idx_reg, pf_idx_next;
    logic [LIW-1:0] l_idx_reg, l_idx_next, lf_idx_reg, lf_idx_next;
    logic           free_found_reg, free_found_next;
    logic [31:0]    ls_save_reg, ls_save_next;
    logic           rej_reason_reg, rej_reason_next;
    logic [31:0]    out_seq_reg, out_seq_next;

    // A tick result is held back one step so that the last one can be marked.
    logic        hold_valid_reg, hold_valid_next;
    logic [1:0]  hold_kind_reg, hold_kind_next;
    logic [47:0] hold_addr_reg, hold_addr_next;
    logic [63:0] hold_chal_reg, hold_chal_next;
    logic [31:0] hold_seq_reg, hold_seq_next;
    logic [31:0] hold_ack_reg, hold_ack_next;
    logic [31:0] hold_el_reg, hold_el_next;

    // Output result register.
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [47:0] out_addr_reg, out_addr_next;
    logic        out_reason_reg, out_reason_next;
    logic [63:0] out_chal_reg, out_chal_next;
    logic [31:0] out_sseq_reg, out_sseq_next;
    logic [31:0] out_ack_reg, out_ack_next;
    logic [31:0] out_el_reg, out_el_next;
    logic        out_last_reg, out_last_next;

    // Table memories and their registered read data.
    logic [47:0] p_addr_mem [PENDING_SLOTS];
    logic [63:0] p_key_mem  [PENDING_SLOTS];
    logic [63:0] p_chal_mem [PENDING_SLOTS];
    logic [31:0] p_ls_mem   [PENDING_SLOTS];
    logic [47:0] l_addr_mem [LINKED_SLOTS];
    logic [31:0] l_ack_mem  [LINKED_SLOTS];
    logic [31:0] l_ls_mem   [LINKED_SLOTS];
    logic [47:0] p_addr_rd;
    logic [63:0] p_key_rd;
    logic [63:0] p_chal_rd;
    logic [31:0] p_ls_rd;
    logic [47:0] l_addr_rd;
    logic [31:0] l_ack_rd;
    logic [31:0] l_ls_rd;

    logic           p_new_we, p_ls_we;
    logic [PIW-1:0] p_widx;
    logic           l_new_we, l_ack_we, l_ls_we;
    logic [LIW-1:0] l_widx;

    chct_pkg::mix_req_t mix_req;
    logic               mix_done;
    logic [63:0]        mix_value;

    logic        out_free;
    logic        can_emit;
    logic        p_adv, l_adv;
    logic [31:0] p_el, l_el;

    chct_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mix_req),
        .done  (mix_done),
        .value (mix_value)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign can_emit = !hold_valid_reg || out_free;
    assign p_el     = now_reg - p_ls_rd;
    assign l_el     = now_reg - l_ls_rd;

    assign cfg_ready    = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        p_valid_next    = p_valid_reg;
        l_valid_next    = l_valid_reg;
        p_idx_next      = p_idx_reg;
        l_idx_next      = l_idx_reg;
        pf_idx_next     = pf_idx_reg;
        lf_idx_next     = lf_idx_reg;
        free_found_next = free_found_reg;
        ls_save_next    = ls_save_reg;
        rej_reason_next = rej_reason_reg;
        out_seq_next    = out_seq_reg;

        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_addr_next  = hold_addr_reg;
        hold_chal_next  = hold_chal_reg;
        hold_seq_next   = hold_seq_reg;
        hold_ack_next   = hold_ack_reg;
        hold_el_next    = hold_el_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_addr_next   = out_addr_reg;
        out_reason_next = out_reason_reg;
        out_chal_next   = out_chal_reg;
        out_sseq_next   = out_sseq_reg;
        out_ack_next    = out_ack_reg;
        out_el_next     = out_el_reg;
        out_last_next   = out_last_reg;

        p_new_we      = 1'b0;
        p_ls_we       = 1'b0;
        p_widx        = p_idx_reg;
        l_new_we      = 1'b0;
        l_ack_we      = 1'b0;
        l_ls_we       = 1'b0;
        l_widx        = l_idx_reg;
        mix_req.start = 1'b0;
        mix_req.load  = cfg_valid && (cfg_index == chct_pkg::CFG_SEED);
        mix_req.seed  = cfg_data;
        p_adv         = 1'b0;
        l_adv         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    p_idx_next      = '0;
                    l_idx_next      = '0;
                    free_found_next = 1'b0;
                    unique case (req_type)
                        chct_pkg::REQ_REQUEST:  state_next = S_CHK;
                        chct_pkg::REQ_DATA:     state_next = S_LRD;
                        default:                state_next = S_PRD;
                    endcase
                end
            end
            S_CHK:
            begin
                if (proto_reg != exp_proto_reg)
                begin
                    rej_reason_next = chct_pkg::REASON_PROTOCOL;
                    state_next      = S_REJ;
                end
                else if (ver_reg != exp_ver_reg)
                begin
                    rej_reason_next = chct_pkg::REASON_VERSION;
                    state_next      = S_REJ;
                end
                else
                begin
                    state_next = S_PRD;
                end
            end
            S_REJ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = chct_pkg::KIND_REJECT;
                    out_addr_next   = addr_reg;
                    out_reason_next = rej_reason_reg;
                    out_chal_next   = 64'd0;
                    out_sseq_next   = 32'd0;
                    out_ack_next    = 32'd0;
                    out_el_next     = 32'd0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_PRD:
            begin
                if (p_valid_reg[p_idx_reg])
                begin
                    state_next = S_PEV;
                end
                else
                begin
                    if ((typ_reg == chct_pkg::REQ_REQUEST) && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        pf_idx_next     = p_idx_reg;
                    end
                    p_adv = 1'b1;
                end
            end
            S_PEV:
            begin
                unique case (typ_reg)
                    chct_pkg::REQ_REQUEST:
                    begin
                        if (p_addr_rd == addr_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            p_adv = 1'b1;
                        end
                    end
                    chct_pkg::REQ_RESPONSE:
                    begin
                        if (p_addr_rd == addr_reg)
                        begin
                            p_valid_next[p_idx_reg] = 1'b0;
                            if (key_reg == (p_key_rd ^ p_chal_rd))
                            begin
                                ls_save_next    = p_ls_rd;
                                free_found_next = 1'b0;
                                l_idx_next      = '0;
                                state_next      = S_LRD;
                            end
                            else
                            begin
                                rej_reason_next = chct_pkg::REASON_PROTOCOL;
                                state_next      = S_REJ;
                            end
                        end
                        else
                        begin
                            p_adv = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Tick: resend the challenge once the interval has run out.
                        if (p_el >= {16'd0, interval_reg})
                        begin
                            if (can_emit)
                            begin
                                if (hold_valid_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_kind_next   = hold_kind_reg;
                                    out_addr_next   = hold_addr_reg;
                                    out_reason_next = 1'b0;
                                    out_chal_next   = hold_chal_reg;
                                    out_sseq_next   = hold_seq_reg;
                                    out_ack_next    = hold_ack_reg;
                                    out_el_next     = hold_el_reg;
                                    out_last_next   = 1'b0;
                                end
                                hold_valid_next = 1'b1;
                                hold_kind_next  = chct_pkg::KIND_CHALLENGE;
                                hold_addr_next  = p_addr_rd;
                                hold_chal_next  = p_chal_rd;
                                hold_seq_next   = 32'd0;
                                hold_ack_next   = 32'd0;
                                hold_el_next    = 32'd0;
                                p_ls_we         = 1'b1;
                                p_adv           = 1'b1;
                            end
                        end
                        else
                        begin
                            p_adv = 1'b1;
                        end
                    end
                endcase
            end
            S_GEN:
            begin
                if (mix_done)
                begin
                    p_new_we                 = 1'b1;
                    p_widx                   = pf_idx_reg;
                    p_valid_next[pf_idx_reg] = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            S_LRD:
            begin
                if (l_valid_reg[l_idx_reg])
                begin
                    state_next = S_LEV;
                end
                else
                begin
                    if ((typ_reg == chct_pkg::REQ_RESPONSE) && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        lf_idx_next     = l_idx_reg;
                    end
                    l_adv = 1'b1;
                end
            end
            S_LEV:
            begin
                unique case (typ_reg)
                    chct_pkg::REQ_RESPONSE:
                    begin
                        if (l_addr_rd == addr_reg)
                        begin
                            // Same peer already established: overwrite its entry.
                            l_new_we   = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            l_adv = 1'b1;
                        end
                    end
                    chct_pkg::REQ_DATA:
                    begin
                        if (l_addr_rd == addr_reg)
                        begin
                            l_ack_we   = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            l_adv = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (l_el >= {16'd0, interval_reg})
                        begin
                            if (can_emit)
                            begin
                                if (hold_valid_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_kind_next   = hold_kind_reg;
                                    out_addr_next   = hold_addr_reg;
                                    out_reason_next = 1'b0;
                                    out_chal_next   = hold_chal_reg;
                                    out_sseq_next   = hold_seq_reg;
                                    out_ack_next    = hold_ack_reg;
                                    out_el_next     = hold_el_reg;
                                    out_last_next   = 1'b0;
                                end
                                hold_valid_next = 1'b1;
                                hold_kind_next  = chct_pkg::KIND_DATA;
                                hold_addr_next  = l_addr_rd;
                                hold_chal_next  = 64'd0;
                                hold_seq_next   = out_seq_reg;
                                hold_ack_next   = l_ack_rd;
                                hold_el_next    = l_el;
                                out_seq_next    = out_seq_reg + 32'd1;
                                l_ls_we         = 1'b1;
                                l_adv           = 1'b1;
                            end
                        end
                        else
                        begin
                            l_adv = 1'b1;
                        end
                    end
                endcase
            end
            S_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = hold_kind_reg;
                    out_addr_next   = hold_addr_reg;
                    out_reason_next = 1'b0;
                    out_chal_next   = hold_chal_reg;
                    out_sseq_next   = hold_seq_reg;
                    out_ack_next    = hold_ack_reg;
                    out_el_next     = hold_el_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Step to the next pending slot, or finish the pending walk.
        if (p_adv)
        begin
            if (p_idx_reg != P_LAST)
            begin
                p_idx_next = p_idx_reg + PIW'(1);
                state_next = S_PRD;
            end
            else
            begin
                unique case (typ_reg)
                    chct_pkg::REQ_REQUEST:
                    begin
                        if (free_found_next)
                        begin
                            mix_req.start = 1'b1;
                            state_next    = S_GEN;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    chct_pkg::REQ_TICK:
                    begin
                        l_idx_next = '0;
                        state_next = S_LRD;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
        end

        // Step to the next linked slot, or finish the linked walk.
        if (l_adv)
        begin
            if (l_idx_reg != L_LAST)
            begin
                l_idx_next = l_idx_reg + LIW'(1);
                state_next = S_LRD;
            end
            else
            begin
                unique case (typ_reg)
                    chct_pkg::REQ_RESPONSE:
                    begin
                        if (free_found_next)
                        begin
                            l_new_we = 1'b1;
                            l_widx   = lf_idx_next;
                        end
                        state_next = S_IDLE;
                    end
                    chct_pkg::REQ_TICK:
                    begin
                        state_next = S_FLUSH;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
        end

        if (l_new_we)
        begin
            l_valid_next[l_widx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            p_valid_reg    <= '0;
            l_valid_reg    <= '0;
            p_idx_reg      <= '0;
            l_idx_reg      <= '0;
            free_found_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_seq_reg    <= 32'd0;
            exp_proto_reg  <= 32'd0;
            exp_ver_reg    <= 8'd0;
            interval_reg   <= chct_pkg::INTERVAL_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            p_valid_reg    <= p_valid_next;
            l_valid_reg    <= l_valid_next;
            p_idx_reg      <= p_idx_next;
            l_idx_reg      <= l_idx_next;
            free_found_reg <= free_found_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            out_seq_reg    <= out_seq_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    chct_pkg::CFG_PROTOCOL: exp_proto_reg <= cfg_data[31:0];
                    chct_pkg::CFG_VERSION:  exp_ver_reg   <= cfg_data[7:0];
                    chct_pkg::CFG_INTERVAL: interval_reg  <= cfg_data[15:0];
                    default:                ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            typ_reg   <= req_type;
            addr_reg  <= peer_address;
            proto_reg <= protocol_in;
            ver_reg   <= version_in;
            key_reg   <= key_or_response;
            seq_reg   <= sequence_in;
            now_reg   <= now_ticks;
        end
        pf_idx_reg      <= pf_idx_next;
        lf_idx_reg      <= lf_idx_next;
        ls_save_reg     <= ls_save_next;
        rej_reason_reg  <= rej_reason_next;
        hold_kind_reg   <= hold_kind_next;
        hold_addr_reg   <= hold_addr_next;
        hold_chal_reg   <= hold_chal_next;
        hold_seq_reg    <= hold_seq_next;
        hold_ack_reg    <= hold_ack_next;
        hold_el_reg     <= hold_el_next;
        out_kind_reg    <= out_kind_next;
        out_addr_reg    <= out_addr_next;
        out_reason_reg  <= out_reason_next;
        out_chal_reg    <= out_chal_next;
        out_sseq_reg    <= out_sseq_next;
        out_ack_reg     <= out_ack_next;
        out_el_reg      <= out_el_next;
        out_last_reg    <= out_last_next;
    end

    // Pending table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (p_new_we)
        begin
            p_addr_mem[p_widx] <= addr_reg;
            p_key_mem[p_widx]  <= key_reg;
            p_chal_mem[p_widx] <= mix_value;
            p_ls_mem[p_widx]   <= 32'd0;
        end
        else if (p_ls_we)
        begin
            p_ls_mem[p_widx] <= now_reg;
        end
        p_addr_rd <= p_addr_mem[p_idx_reg];
        p_key_rd  <= p_key_mem[p_idx_reg];
        p_chal_rd <= p_chal_mem[p_idx_reg];
        p_ls_rd   <= p_ls_mem[p_idx_reg];
    end

    // Linked table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (l_new_we)
        begin
            l_addr_mem[l_widx] <= addr_reg;
            l_ack_mem[l_widx]  <= 32'd0;
            l_ls_mem[l_widx]   <= ls_save_reg;
        end
        else if (l_ack_we)
        begin
            l_ack_mem[l_widx] <= seq_reg;
        end
        else if (l_ls_we)
        begin
            l_ls_mem[l_widx] <= now_reg;
        end
        l_addr_rd <= l_addr_mem[l_idx_reg];
        l_ack_rd  <= l_ack_mem[l_idx_reg];
        l_ls_rd   <= l_ls_mem[l_idx_reg];
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign packet_kind     = out_kind_reg;
    assign dest_address    = out_addr_reg;
    assign reject_reason   = out_reason_reg;
    assign challenge_value = out_chal_reg;
    assign server_sequence = out_sseq_reg;
    assign ack_number      = out_ack_reg;
    assign elapsed_ticks   = out_el_reg;
    assign last_of_run     = out_last_reg;

endmodule
